// ----- hdl/hd44780_nibble_write_queue_defines.svh -----
// Assertion macros for the write queue checker.
`ifndef HD44780_NIBBLE_WRITE_QUEUE_DEFINES_SVH
`define HD44780_NIBBLE_WRITE_QUEUE_DEFINES_SVH

// Check a property on the rising edge of aclk, idle while aresetn is low.
`define HD_NWQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition on a result word holds whenever m_valid is high.
`define HD_NWQ_ASSERT_OUT(label, cond, msg) \
    `HD_NWQ_ASSERT(label, m_valid |-> (cond), msg)

`endif

// ----- hdl/hd_nwq_pkg.sv -----
package hd_nwq_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_OPEN  = 2'd1,
        REQ_TEXT  = 2'd2,
        REQ_CLOSE = 2'd3
    } req_code_t;

    // Input word
    typedef struct packed {
        req_code_t   req_type;
        logic [5:0]  col;
        logic        row;
        logic [7:0]  char_code;
    } req_t;

    // Result word
    typedef struct packed {
        logic [3:0]  nibble;
        logic        rs;
        logic        strobe_res;
        logic        close_ok;
        logic        trans_done;
        logic        queue_full;
    } res_t;

    // Store entry: last-byte mark over the byte
    typedef struct packed {
        logic        last;
        logic [7:0]  data;
    } entry_t;

endpackage

// ----- hdl/hd44780_nibble_write_queue.sv -----
// Text-write queue for a character LCD in 4-bit mode.
// Input channel s_valid/s_ready/s_data carries one request word: tick, open
// (column and row), text byte, or close. Every request yields exactly one
// result word on m_valid/m_ready/m_data, in request order.
// Open stores the address command, text bytes follow into a circular byte
// store, close commits (close_ok=1) or rejects and discards the transaction.
// Each tick sends one nibble of the oldest committed byte, high half first,
// with rs=0 for the address byte and trans_done on the last nibble.
// Open, text, close and idle ticks give their result in the cycle after
// acceptance; a tick that sends a nibble first reads the byte store, a
// synchronous RAM with a registered read port, then loads the output.
// Requests are taken one per cycle while the output drains, except that a
// tick that emits a nibble holds the next one off until its read is done.
// A result waits in an output register; the next request is taken while it
// is being drained, and input stalls while it is held by m_ready low.
// Reset (aresetn low, synchronous) empties the queue and clears all pointers;
// the store contents are not cleared, no clearing pass is needed.
module hd44780_nibble_write_queue #(
    parameter int MAX_TRANS   = 8,
    parameter int STORE_DEPTH = 256,
    parameter int MAX_TEXT    = 62
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hd_nwq_pkg::req_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hd_nwq_pkg::res_t  m_data
);

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(MAX_TRANS + 1);
    localparam int LEN_W = $clog2(MAX_TEXT + 1);

    // Byte store
    hd_nwq_pkg::entry_t store_mem [STORE_DEPTH];
    hd_nwq_pkg::entry_t rd_data_reg;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    hd_nwq_pkg::entry_t mem_wdata;
    logic               mem_re;

    // Control state
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0] commit_ptr_reg, commit_ptr_next;
    logic [PTR_W-1:0] fill_ptr_reg, fill_ptr_next;
    logic [LEN_W-1:0] open_len_reg, open_len_next;
    logic             open_active_reg, open_active_next;
    logic             open_ovf_reg, open_ovf_next;
    logic [CNT_W-1:0] trans_count_reg, trans_count_next;
    logic             sending_reg, sending_next;
    logic             low_half_reg, low_half_next;
    logic             at_cmd_reg, at_cmd_next;
    logic             pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;

    // Payload
    logic [7:0]       last_byte_reg, last_byte_next;
    hd_nwq_pkg::res_t m_data_reg, res_next;
    logic             load_out;
    logic             accept;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_W'(STORE_DEPTH - 1) : p - 1'b1;
    endfunction

    assign s_ready = !pend_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Decode the request, or finish a pending nibble from the read data
    always_comb begin
        read_ptr_next    = read_ptr_reg;
        commit_ptr_next  = commit_ptr_reg;
        fill_ptr_next    = fill_ptr_reg;
        open_len_next    = open_len_reg;
        open_active_next = open_active_reg;
        open_ovf_next    = open_ovf_reg;
        trans_count_next = trans_count_reg;
        sending_next     = sending_reg;
        low_half_next    = low_half_reg;
        at_cmd_next      = at_cmd_reg;
        pend_next        = pend_reg;
        last_byte_next   = last_byte_reg;
        mem_we           = 1'b0;
        mem_waddr        = fill_ptr_reg;
        mem_wdata        = '{last: 1'b0, data: s_data.char_code};
        mem_re           = 1'b0;
        load_out         = 1'b0;
        res_next         = '0;

        if (pend_reg) begin
            // Emit one nibble of the byte at the read pointer
            pend_next           = 1'b0;
            load_out            = 1'b1;
            res_next.nibble     = low_half_reg ? rd_data_reg.data[3:0] : rd_data_reg.data[7:4];
            res_next.rs         = !at_cmd_reg;
            res_next.strobe_res = 1'b1;
            res_next.queue_full = (trans_count_reg == CNT_W'(MAX_TRANS));
            if (low_half_reg) begin
                read_ptr_next = ptr_inc(read_ptr_reg);
                at_cmd_next   = 1'b0;
                if (rd_data_reg.last) begin
                    res_next.trans_done = 1'b1;
                    sending_next        = 1'b0;
                    at_cmd_next         = 1'b1;
                end
            end
            low_half_next = !low_half_reg;
        end else if (accept) begin
            unique case (s_data.req_type)
                hd_nwq_pkg::REQ_OPEN: begin
                    // Restart at the commit point and store the address command if there is room
                    fill_ptr_next    = commit_ptr_reg;
                    open_len_next    = '0;
                    open_ovf_next    = 1'b0;
                    open_active_next = 1'b1;
                    if (ptr_inc(commit_ptr_reg) == read_ptr_reg) begin
                        open_ovf_next = 1'b1;
                    end else begin
                        mem_we         = 1'b1;
                        mem_waddr      = commit_ptr_reg;
                        mem_wdata      = '{last: 1'b0, data: {1'b1, s_data.row, s_data.col}};
                        fill_ptr_next  = ptr_inc(commit_ptr_reg);
                        last_byte_next = {1'b1, s_data.row, s_data.col};
                    end
                end
                hd_nwq_pkg::REQ_TEXT: begin
                    // Append a text byte, drop it if too long or out of room
                    if (open_active_reg) begin
                        if (open_len_reg >= LEN_W'(MAX_TEXT)) begin
                            open_ovf_next = 1'b1;
                        end else if (ptr_inc(fill_ptr_reg) == read_ptr_reg) begin
                            open_ovf_next = 1'b1;
                        end else begin
                            mem_we         = 1'b1;
                            fill_ptr_next  = ptr_inc(fill_ptr_reg);
                            last_byte_next = s_data.char_code;
                            if (!open_ovf_reg) begin
                                open_len_next = open_len_reg + 1'b1;
                            end
                        end
                    end
                end
                hd_nwq_pkg::REQ_CLOSE: begin
                    // Commit by marking the last byte, or roll back
                    if (open_active_reg && !open_ovf_reg &&
                        trans_count_reg < CNT_W'(MAX_TRANS)) begin
                        mem_we            = 1'b1;
                        mem_waddr         = ptr_dec(fill_ptr_reg);
                        mem_wdata         = '{last: 1'b1, data: last_byte_reg};
                        commit_ptr_next   = fill_ptr_reg;
                        trans_count_next  = trans_count_reg + 1'b1;
                        res_next.close_ok = 1'b1;
                    end else begin
                        fill_ptr_next = commit_ptr_reg;
                    end
                    open_active_next = 1'b0;
                    open_ovf_next    = 1'b0;
                    open_len_next    = '0;
                end
                hd_nwq_pkg::REQ_TICK: begin
                    // Start the next transaction if idle, then read its byte
                    if (!sending_reg && trans_count_reg != '0) begin
                        sending_next     = 1'b1;
                        trans_count_next = trans_count_reg - 1'b1;
                        low_half_next    = 1'b0;
                        at_cmd_next      = 1'b1;
                    end
                    if (sending_reg || trans_count_reg != '0) begin
                        mem_re    = 1'b1;
                        pend_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (s_data.req_type != hd_nwq_pkg::REQ_TICK || !pend_next) begin
                load_out            = 1'b1;
                res_next.queue_full = (trans_count_next == CNT_W'(MAX_TRANS));
            end
        end
    end

    // Hand over the result word, drop it once taken
    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_ptr_reg    <= '0;
            commit_ptr_reg  <= '0;
            fill_ptr_reg    <= '0;
            open_len_reg    <= '0;
            open_active_reg <= 1'b0;
            open_ovf_reg    <= 1'b0;
            trans_count_reg <= '0;
            sending_reg     <= 1'b0;
            low_half_reg    <= 1'b0;
            at_cmd_reg      <= 1'b1;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            read_ptr_reg    <= read_ptr_next;
            commit_ptr_reg  <= commit_ptr_next;
            fill_ptr_reg    <= fill_ptr_next;
            open_len_reg    <= open_len_next;
            open_active_reg <= open_active_next;
            open_ovf_reg    <= open_ovf_next;
            trans_count_reg <= trans_count_next;
            sending_reg     <= sending_next;
            low_half_reg    <= low_half_next;
            at_cmd_reg      <= at_cmd_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        last_byte_reg <= last_byte_next;
        if (load_out) begin
            m_data_reg <= res_next;
        end
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[read_ptr_reg];
        end
    end

endmodule

// ----- hdl/hd_nwq_checker.sv -----
`include "hd44780_nibble_write_queue_defines.svh"

module hd_nwq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input hd_nwq_pkg::req_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input hd_nwq_pkg::res_t  m_data
);

    // Hold a stalled result word
    `HD_NWQ_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word changed while stalled")

    // Answer close_ok only to a close request
    `HD_NWQ_ASSERT(a_close_only, s_valid && s_ready && s_data.req_type != hd_nwq_pkg::REQ_CLOSE |=> !(m_valid && m_data.close_ok), "close_ok on a request that is not a close")

    // Keep data lines quiet when no nibble is sent
    `HD_NWQ_ASSERT_OUT(a_quiet_lines, m_data.strobe_res || (m_data.nibble == 4'd0 && !m_data.rs), "data lines driven without strobe")

    // Flag completion only with a nibble
    `HD_NWQ_ASSERT_OUT(a_done_strobe, !m_data.trans_done || m_data.strobe_res, "trans_done without a nibble")

    // Never answer a close and send a nibble in one word
    `HD_NWQ_ASSERT_OUT(a_close_excl, !(m_data.close_ok && m_data.strobe_res), "close_ok together with a nibble")

endmodule

bind hd44780_nibble_write_queue hd_nwq_checker u_hd_nwq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/sv/lcd_nibble_checker.sv -----
module lcd_nibble_checker #(
    parameter int MAX_TRANS   = 8,
    parameter int STORE_DEPTH = 256,
    parameter int MAX_TEXT    = 62
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  hd_nwq_pkg::req_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  hd_nwq_pkg::res_t  m_data,
    output int                error_count,
    output int                expected_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_W = $clog2(STORE_DEPTH);
    typedef logic [PTR_W-1:0] ptr_t;

    // Shadow copy of the queue state
    hd_nwq_pkg::entry_t text_store [STORE_DEPTH];
    ptr_t       rd_ptr, commit_ptr, fill_ptr;
    logic [5:0] open_len;
    logic [6:0] waiting_trans;
    bit         open_busy, open_spill, sending, low_half, at_address;

    // Result words predicted but not yet drained, oldest first
    hd_nwq_pkg::res_t lcd_words_due [$];

    function automatic ptr_t ptr_next(ptr_t p);
        return (p == ptr_t'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic ptr_t ptr_prev(ptr_t p);
        return (p == '0) ? ptr_t'(STORE_DEPTH - 1) : p - 1'b1;
    endfunction

    // Append one byte, keeping one free entry; drop it and flag the spill otherwise
    function automatic void append_byte(logic [7:0] b);
        if (ptr_next(fill_ptr) == rd_ptr) begin
            open_spill = 1'b1;
        end else begin
            text_store[fill_ptr] = '{last: 1'b0, data: b};
            fill_ptr = ptr_next(fill_ptr);
        end
    endfunction

    // Advance the shadow state by one request word and return its result word
    function automatic hd_nwq_pkg::res_t lcd_step(hd_nwq_pkg::req_t w);
        hd_nwq_pkg::res_t   r;
        hd_nwq_pkg::entry_t e;
        ptr_t               tail;
        r = '0;
        case (w.req_type)
            hd_nwq_pkg::REQ_OPEN: begin
                fill_ptr   = commit_ptr;
                open_len   = '0;
                open_spill = 1'b0;
                open_busy  = 1'b1;
                append_byte({1'b1, 7'(w.col) + {w.row, 6'b0}});
            end
            hd_nwq_pkg::REQ_TEXT: begin
                if (open_busy) begin
                    if (open_len >= 6'(MAX_TEXT)) begin
                        open_spill = 1'b1;
                    end else begin
                        append_byte(w.char_code);
                        if (!open_spill) open_len++;
                    end
                end
            end
            hd_nwq_pkg::REQ_CLOSE: begin
                if (open_busy && !open_spill && waiting_trans < 7'(MAX_TRANS)) begin
                    tail = ptr_prev(fill_ptr);
                    text_store[tail].last = 1'b1;
                    commit_ptr = fill_ptr;
                    waiting_trans++;
                    r.close_ok = 1'b1;
                end else begin
                    fill_ptr = commit_ptr;
                end
                open_busy  = 1'b0;
                open_spill = 1'b0;
                open_len   = '0;
            end
            hd_nwq_pkg::REQ_TICK: begin
                if (!sending && waiting_trans > 0) begin
                    sending    = 1'b1;
                    waiting_trans--;
                    low_half   = 1'b0;
                    at_address = 1'b1;
                end
                if (sending) begin
                    e = text_store[rd_ptr];
                    r.nibble     = low_half ? e.data[3:0] : e.data[7:4];
                    r.rs         = !at_address;
                    r.strobe_res = 1'b1;
                    if (low_half) begin
                        rd_ptr     = ptr_next(rd_ptr);
                        at_address = 1'b0;
                        if (e.last) begin
                            r.trans_done = 1'b1;
                            sending      = 1'b0;
                            at_address   = 1'b1;
                        end
                    end
                    low_half = !low_half;
                end
            end
        endcase
        r.queue_full = (waiting_trans == 7'(MAX_TRANS));
        return r;
    endfunction

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    // Watch both channels; compare drained words, then predict accepted ones
    always @(posedge aclk) begin
        hd_nwq_pkg::res_t want;
        if (!aresetn) begin
            rd_ptr        = '0;
            commit_ptr    = '0;
            fill_ptr      = '0;
            open_len      = '0;
            waiting_trans = '0;
            open_busy     = 1'b0;
            open_spill    = 1'b0;
            sending       = 1'b0;
            low_half      = 1'b0;
            at_address    = 1'b1;
            lcd_words_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (lcd_words_due.size() == 0) begin
                    $error("result word with no request waiting: %h", m_data);
                    error_count++;
                end else begin
                    want = lcd_words_due.pop_front();
                    check_field("nibble", want.nibble, m_data.nibble);
                    check_field("rs", 4'(want.rs), 4'(m_data.rs));
                    check_field("strobe_res", 4'(want.strobe_res), 4'(m_data.strobe_res));
                    check_field("close_ok", 4'(want.close_ok), 4'(m_data.close_ok));
                    check_field("trans_done", 4'(want.trans_done), 4'(m_data.trans_done));
                    check_field("queue_full", 4'(want.queue_full), 4'(m_data.queue_full));
                end
            end
            if (s_valid && s_ready) begin
                lcd_words_due.push_back(lcd_step(s_data));
            end
        end
        expected_count = lcd_words_due.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TRANS    = 8;
    localparam int STORE_DEPTH  = 256;
    localparam int MAX_TEXT     = 62;
    localparam int CLK_PERIOD   = 10;
    localparam int TOTAL_ITEMS  = 1500;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    hd_nwq_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    hd_nwq_pkg::res_t m_data;

    int   error_count;
    int   expected_count;
    int   sent_count  = 0;
    bit   hold_wanted = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    hd44780_nibble_write_queue #(
        .MAX_TRANS   (MAX_TRANS),
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_TEXT    (MAX_TEXT)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    lcd_nibble_checker #(
        .MAX_TRANS   (MAX_TRANS),
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_TEXT    (MAX_TEXT)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .error_count    (error_count),
        .expected_count (expected_count)
    );

    // Offer one request word, idling first at random, and hold it until taken
    task automatic send_req(hd_nwq_pkg::req_code_t code, logic [5:0] col, logic row,
                            logic [7:0] ch);
        if (!(sent_count >= 1000 && sent_count < 1300)) begin
            while ($urandom_range(0, 99) < 29) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= '{req_type: code, col: col, row: row, char_code: ch};
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (sent_count == HOLD_AT) hold_wanted = 1'b1;
    endtask

    task automatic send_text(int count);
        repeat (count) send_req(hd_nwq_pkg::REQ_TEXT, 6'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_ticks(int count);
        repeat (count) send_req(hd_nwq_pkg::REQ_TICK, 6'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_open();
        send_req(hd_nwq_pkg::REQ_OPEN, 6'($urandom), 1'($urandom), 8'($urandom));
    endtask

    task automatic send_close();
        send_req(hd_nwq_pkg::REQ_CLOSE, 6'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // Drain result words; stall at random, once for a long stretch
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_wanted && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (sent_count >= 900 && sent_count < 1150) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 29);
            end
        end
    end

    // Give up on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int  text_len;
        int  pick;
        int  sel;
        bit  flooding;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Idle tick, stray text and stray close with nothing open
        send_ticks(1);
        send_req(hd_nwq_pkg::REQ_TEXT, 6'd0, 1'b0, 8'hA5);
        send_close();

        // Lowest address, extreme text bytes
        send_req(hd_nwq_pkg::REQ_OPEN, 6'd0, 1'b0, 8'h00);
        send_req(hd_nwq_pkg::REQ_TEXT, 6'h3F, 1'b1, 8'h00);
        send_req(hd_nwq_pkg::REQ_TEXT, 6'h00, 1'b0, 8'hFF);
        send_close();

        // Highest address, then a second open that discards it
        send_req(hd_nwq_pkg::REQ_OPEN, 6'h3F, 1'b1, 8'hFF);
        send_req(hd_nwq_pkg::REQ_TEXT, 6'h15, 1'b0, 8'h5A);
        send_req(hd_nwq_pkg::REQ_OPEN, 6'd5, 1'b0, 8'h00);
        send_req(hd_nwq_pkg::REQ_TEXT, 6'h2A, 1'b1, 8'h41);
        send_close();

        // Replay both transactions, then tick on an empty queue
        send_ticks(12);

        while (sent_count < TOTAL_ITEMS) begin
            flooding = ((sent_count / 200) % 3) == 1;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // Well-formed transaction; long text while flooding fills the store
                if (flooding) begin
                    text_len = $urandom_range(16, MAX_TEXT);
                end else begin
                    sel = $urandom_range(0, 99);
                    if (sel < 80)      text_len = $urandom_range(0, 6);
                    else if (sel < 92) text_len = $urandom_range(7, 40);
                    else               text_len = $urandom_range(MAX_TEXT - 2, MAX_TEXT + 4);
                end
                send_open();
                send_text(text_len);
                send_close();
                if (!flooding) begin
                    send_ticks($urandom_range(0, 2 * text_len + 6));
                    if ($urandom_range(0, 9) == 0) send_ticks(120);
                end
            end else if (pick < 85) begin
                // Broken transaction: left open, or restarted by a second open
                send_open();
                send_text($urandom_range(0, 4));
                if ($urandom_range(0, 1)) begin
                    send_open();
                    send_text($urandom_range(0, 4));
                    send_close();
                end
            end else begin
                // Noise words of any kind
                repeat ($urandom_range(1, 6)) begin
                    send_req(hd_nwq_pkg::req_code_t'($urandom_range(0, 3)), 6'($urandom),
                             1'($urandom), 8'($urandom));
                end
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (expected_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
